// File: rtl/prcb_pkg.sv
// Shared constants, types and iteration steps for point_radius_clamp_bbox.
// No dependencies.
`default_nettype none

package prcb_pkg;

  // Default number of fraction bits of the fixed-point coordinates
  localparam int unsigned FractionBitsDef = 10;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_RESTRICT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RADIUS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCANNER_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCANNER_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCANNER_Z = 3'd4;

  // Sum of squares, root and division widths
  localparam int unsigned SumW  = 66;
  localparam int unsigned RootW = 34;

  localparam logic signed [31:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;

  typedef struct packed {
    logic [RootW+2:0] rem;
    logic [RootW-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [RootW-1:0] quo;
  } div_st_t;

  // One digit of the restoring square root (two radicand bits in)
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [1:0] pair);
    logic [RootW+2:0] r;
    logic [RootW+2:0] trial;
    sqrt_st_t         o;
    r     = {st.rem[RootW:0], pair};
    trial = {1'b0, st.root, 2'b01};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {st.root[RootW-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {st.root[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of the restoring division
  function automatic div_st_t div_step(div_st_t st, logic nbit, logic [RootW-1:0] dvs);
    logic [RootW:0] t;
    logic [RootW:0] diff;
    div_st_t        o;
    t    = {st.rem, nbit};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      o.rem = diff[RootW-1:0];
      o.quo = {st.quo[RootW-2:0], 1'b1};
    end else begin
      o.rem = t[RootW-1:0];
      o.quo = {st.quo[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: rtl/point_radius_clamp_bbox.sv
// Point radius clamp with running bounding box: top level; depends on prcb_pkg.
// Flow: a passing point goes from the squares state to the result state; a clamped
// one adds the square root, then multiply, divider load and divide for each axis.
// One point at a time: none is taken until the block is back in idle, and a stalled
// output holds it in the result state; one shared multiplier, 2-bit-per-cycle root/divide.
// Reset: asynchronous active low; control and config registers 0, box corners to empty (max/min).
`default_nettype none

module point_radius_clamp_bbox
  import prcb_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  // point request
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [31:0]  point_x_i,
  input  wire logic signed [31:0]  point_y_i,
  input  wire logic signed [31:0]  point_z_i,
  input  wire logic                scene_start_i,
  // result request
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       out_x_o,
  output logic signed [31:0]       out_y_o,
  output logic signed [31:0]       out_z_o,
  output logic                     was_shifted_o,
  output logic signed [31:0]       box_min_x_o,
  output logic signed [31:0]       box_min_y_o,
  output logic signed [31:0]       box_min_z_o,
  output logic signed [31:0]       box_max_x_o,
  output logic signed [31:0]       box_max_y_o,
  output logic signed [31:0]       box_max_z_o
);

  // radius in fixed point: whole meters shifted up by the fraction bits
  localparam int unsigned RadW = 16 + FRACTION_BITS;
  localparam int unsigned MulW = 33;
  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] SqLast   = 5'd4;
  localparam logic [CntW-1:0] StepLast = 5'd16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;  // squares and R^2 through the multiplier
  localparam logic [2:0] ST_SQRT = 3'd2;  // floor square root of the distance sum
  localparam logic [2:0] ST_MUL  = 3'd3;  // R * |d| for one axis
  localparam logic [2:0] ST_DLD  = 3'd4;  // add half the divisor, load the divider
  localparam logic [2:0] ST_DIV  = 3'd5;  // rounded quotient, two bits a cycle
  localparam logic [2:0] ST_OUT  = 3'd6;  // result register and box update

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      axis_q;

  // configuration
  logic               restrict_q;
  logic [15:0]        radius_q;
  logic signed [31:0] scan_q [3];

  // per item
  logic signed [31:0] pt_q   [3];
  logic [MulW-1:0]    mag_q  [3];
  logic               neg_q  [3];
  logic signed [31:0] res_q  [3];
  logic               scene_q;
  logic               shift_q;

  logic [SumW-1:0]    prod_q;
  logic [SumW-1:0]    sum_q;
  logic [2*RootW-1:0] radicand_q;
  sqrt_st_t           sq_q;
  logic [RootW-1:0]   dist_q;
  div_st_t            dv_q;
  logic [RootW-1:0]   nrest_q;

  // box and result registers
  logic signed [31:0] min_q [3];
  logic signed [31:0] max_q [3];
  logic               out_valid_q;
  logic signed [31:0] out_q [3];
  logic               out_shift_q;

  logic in_acc, out_take, out_free;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // shared multiplier operands
  logic [RadW-1:0] rad;
  logic [MulW-1:0] rad_ext, mag_sel, mul_a, mul_b;
  logic [1:0]      mag_idx;
  assign rad     = RadW'(radius_q) << FRACTION_BITS;
  assign rad_ext = MulW'(rad);
  assign mag_idx = (state_q == ST_SQ) ? cnt_q[1:0] : axis_q;

  always_comb begin
    case (mag_idx)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
    mul_a = mag_sel;
    mul_b = mag_sel;
    if (state_q == ST_MUL) begin
      mul_a = rad_ext;
    end else if (state_q == ST_SQ && cnt_q == 5'd3) begin
      mul_a = rad_ext;
      mul_b = rad_ext;
    end
  end

  // two root digits and two quotient bits per cycle
  sqrt_st_t sq1, sq2;
  div_st_t  dv1, dv2;
  assign sq1 = sqrt_step(sq_q, radicand_q[2*RootW-1 -: 2]);
  assign sq2 = sqrt_step(sq1, radicand_q[2*RootW-3 -: 2]);
  assign dv1 = div_step(dv_q, nrest_q[RootW-1], dist_q);
  assign dv2 = div_step(dv1, nrest_q[RootW-2], dist_q);

  // numerator of the rounded scale: R*|d| + floor(dist/2)
  logic [SumW-1:0] numer;
  assign numer = prod_q + SumW'(dist_q >> 1);

  logic signed [34:0] moved;
  logic signed [31:0] scan_sel;
  always_comb begin
    case (axis_q)
      2'd0:    scan_sel = scan_q[0];
      2'd1:    scan_sel = scan_q[1];
      default: scan_sel = scan_q[2];
    endcase
    if (neg_q[axis_q])
      moved = 35'(scan_sel) - $signed({1'b0, dv2.quo});
    else
      moved = 35'(scan_sel) + $signed({1'b0, dv2.quo});
  end

  logic clamp;
  assign clamp = restrict_q && (radius_q != 16'd0) && (sum_q > prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SQ;
      ST_SQ:   if (cnt_q == SqLast) state_d = clamp ? ST_SQRT : ST_OUT;
      ST_SQRT: if (cnt_q == StepLast) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DLD;
      ST_DLD:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == StepLast) state_d = (axis_q == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control, configuration, output valid and bounding box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      restrict_q  <= 1'b0;
      radius_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        scan_q[i] <= '0;
        min_q[i]  <= CoordMax;
        max_q[i]  <= CoordMin;
      end
    end else begin
      state_q <= state_d;
      if (state_q != state_d || state_q == ST_DLD) cnt_q <= '0;
      else cnt_q <= cnt_q + 5'd1;
      if (state_q == ST_IDLE) axis_q <= '0;
      else if (state_q == ST_DIV && cnt_q == StepLast) axis_q <= axis_q + 2'd1;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RESTRICT:  restrict_q <= cfg_data_i[0];
          REG_RADIUS:    radius_q   <= cfg_data_i[15:0];
          REG_SCANNER_X: scan_q[0]  <= cfg_data_i;
          REG_SCANNER_Y: scan_q[1]  <= cfg_data_i;
          REG_SCANNER_Z: scan_q[2]  <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          logic signed [31:0] bmin, bmax;
          bmin = scene_q ? CoordMax : min_q[i];
          bmax = scene_q ? CoordMin : max_q[i];
          min_q[i] <= (res_q[i] < bmin) ? res_q[i] : bmin;
          max_q[i] <= (res_q[i] > bmax) ? res_q[i] : bmax;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
      scene_q <= scene_start_i;
      sum_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] d;
        logic signed [31:0] p;
        case (i)
          0:       p = point_x_i;
          1:       p = point_y_i;
          default: p = point_z_i;
        endcase
        d = 33'(p) - 33'(scan_q[i]);
        neg_q[i] <= d[32];
        mag_q[i] <= d[32] ? MulW'(-d) : MulW'(d);
      end
    end
    case (state_q)
      ST_SQ: begin
        if (cnt_q != 5'd0 && cnt_q != SqLast) sum_q <= sum_q + prod_q;
        if (cnt_q == SqLast) begin
          shift_q    <= clamp;
          radicand_q <= {2'b00, sum_q};
          sq_q       <= '0;
          for (int i = 0; i < 3; i++) res_q[i] <= pt_q[i];
        end
      end
      ST_SQRT: begin
        sq_q       <= sq2;
        radicand_q <= radicand_q << 4;
        if (cnt_q == StepLast) dist_q <= sq2.root;
      end
      ST_DLD: begin
        dv_q.rem <= RootW'(numer[SumW-1:RootW]);
        dv_q.quo <= '0;
        nrest_q  <= numer[RootW-1:0];
      end
      ST_DIV: begin
        dv_q    <= dv2;
        nrest_q <= nrest_q << 2;
        if (cnt_q == StepLast) res_q[axis_q] <= moved[31:0];
      end
      ST_OUT: begin
        if (out_free) begin
          for (int i = 0; i < 3; i++) out_q[i] <= res_q[i];
          out_shift_q <= shift_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_q[0];
  assign out_y_o       = out_q[1];
  assign out_z_o       = out_q[2];
  assign was_shifted_o = out_shift_q;
  assign box_min_x_o   = min_q[0];
  assign box_min_y_o   = min_q[1];
  assign box_min_z_o   = min_q[2];
  assign box_max_x_o   = max_q[0];
  assign box_max_y_o   = max_q[1];
  assign box_max_z_o   = max_q[2];

endmodule

`default_nettype wire
